### rtl/yuvrgb_pkg.sv
// shared types and constants for the yuyv to bottom-up rgb converter
`default_nettype none

package yuvrgb_pkg;

    // configuration port
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    // payload widths
    localparam int PIX_W = 8;
    localparam int OFF_W = 26;
    localparam int IN_W  = 4 * PIX_W;
    localparam int OUT_W = 80;

    // q14 color coefficients
    localparam int FRAC_BITS = 14;
    localparam int PROD_W    = 24;
    localparam logic signed [15:0] COEF_BU = 16'sd29032;
    localparam logic signed [15:0] COEF_GU = 16'sd5638;
    localparam logic signed [15:0] COEF_GV = 16'sd11700;
    localparam logic signed [15:0] COEF_RV = 16'sd22970;
    localparam logic signed [8:0]  CHROMA_OFFSET = 9'sd128;

    // pipeline advance controls shared by lanes and address path
    typedef struct packed {
        logic accept;
        logic adv1;
        logic adv2;
        logic adv3;
    } pipe_ctrl_t;

endpackage

`default_nettype wire

### rtl/yuvrgb_lane.sv
// one pixel color lane: q14 multiply stage, then sum, floor and saturate stage
`default_nettype none

module yuvrgb_lane (
    input  wire logic                    clk,
    input  wire yuvrgb_pkg::pipe_ctrl_t  ctrl,
    input  wire logic [7:0]              luma,
    input  wire logic [7:0]              chroma_u,
    input  wire logic [7:0]              chroma_v,
    output logic [7:0]                   blue,
    output logic [7:0]                   green,
    output logic [7:0]                   red
);
    import yuvrgb_pkg::*;

    logic signed [8:0]        du;
    logic signed [8:0]        dv;
    logic signed [PROD_W-1:0] prod_b_next;
    logic signed [PROD_W-1:0] prod_g_next;
    logic signed [PROD_W-1:0] prod_r_next;
    logic signed [PROD_W-1:0] prod_b_reg;
    logic signed [PROD_W-1:0] prod_g_reg;
    logic signed [PROD_W-1:0] prod_r_reg;
    logic [7:0]               luma_reg;
    logic signed [PROD_W-1:0] luma_q;
    logic signed [PROD_W-1:0] sum_b;
    logic signed [PROD_W-1:0] sum_g;
    logic signed [PROD_W-1:0] sum_r;
    logic [7:0]               blue_next;
    logic [7:0]               green_next;
    logic [7:0]               red_next;
    logic [7:0]               blue_reg;
    logic [7:0]               green_reg;
    logic [7:0]               red_reg;

    // floor by shift, then clamp to 0..255
    function automatic logic [7:0] sat_q14(input logic signed [PROD_W-1:0] sum);
        logic [PROD_W-FRAC_BITS-1:0] q;
        q = sum[PROD_W-1:FRAC_BITS];
        if (q[PROD_W-FRAC_BITS-1])
            sat_q14 = 8'd0;
        else if (q[8])
            sat_q14 = 8'd255;
        else
            sat_q14 = q[7:0];
    endfunction

    // chroma offsets and products
    always_comb
    begin
        du          = $signed({1'b0, chroma_u}) - CHROMA_OFFSET;
        dv          = $signed({1'b0, chroma_v}) - CHROMA_OFFSET;
        prod_b_next = PROD_W'(COEF_BU) * PROD_W'(du);
        prod_g_next = -(PROD_W'(COEF_GU) * PROD_W'(du)) - PROD_W'(COEF_GV) * PROD_W'(dv);
        prod_r_next = PROD_W'(COEF_RV) * PROD_W'(dv);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv2)
        begin
            prod_b_reg <= prod_b_next;
            prod_g_reg <= prod_g_next;
            prod_r_reg <= prod_r_next;
            luma_reg   <= luma;
        end
    end

    // add scaled luma and saturate
    always_comb
    begin
        luma_q     = $signed({2'b00, luma_reg, {FRAC_BITS{1'b0}}});
        sum_b      = luma_q + prod_b_reg;
        sum_g      = luma_q + prod_g_reg;
        sum_r      = luma_q + prod_r_reg;
        blue_next  = sat_q14(sum_b);
        green_next = sat_q14(sum_g);
        red_next   = sat_q14(sum_r);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv3)
        begin
            blue_reg  <= blue_next;
            green_reg <= green_next;
            red_reg   <= red_next;
        end
    end

    assign blue  = blue_reg;
    assign green = green_reg;
    assign red   = red_reg;

endmodule

`default_nettype wire

### rtl/yuvrgb_addr.sv
// frame size registers, pair and line counters and bottom-up byte offset pipeline
`default_nettype none

module yuvrgb_addr #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire yuvrgb_pkg::pipe_ctrl_t              ctrl,
    input  wire logic                                cfg_we,
    input  wire logic [yuvrgb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [yuvrgb_pkg::CFG_W-1:0]        cfg_wdata,
    output logic [yuvrgb_pkg::OFF_W-1:0]             byte_offset,
    output logic                                     frame_end
);
    import yuvrgb_pkg::*;

    localparam int COL_W  = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1;
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int PAIR_W = $clog2(MAX_WIDTH / 2 + 1);
    localparam int LINE_W = $clog2(MAX_HEIGHT + 1);
    localparam int CMP_W  = CFG_W + 1;
    localparam int MUL_W  = ROW_W + PAIR_W + 1;
    localparam logic [CMP_W-1:0] PAIR_MAX = CMP_W'(MAX_WIDTH / 2);
    localparam logic [CMP_W-1:0] LINE_MAX = CMP_W'(MAX_HEIGHT);
    localparam logic [CMP_W-1:0] CMP_ONE  = CMP_W'(1);
    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;

    logic [CMP_W-1:0]  pairs_raw;
    logic [CMP_W-1:0]  lines_raw;
    logic [CMP_W-1:0]  pairs_cl;
    logic [CMP_W-1:0]  lines_cl;
    logic [PAIR_W-1:0] pairs;
    logic [PAIR_W-1:0] pairs_m1;
    logic [LINE_W-1:0] lines;
    logic [LINE_W-1:0] lines_m1;
    logic [COL_W-1:0]  col_c;
    logic [ROW_W-1:0]  row_c;
    logic              last_col;
    logic              last_row;
    logic [LINE_W-1:0] line_rev_full;

    logic [ROW_W-1:0]  line_rev_reg;
    logic [PAIR_W:0]   wpix_reg;
    logic [COL_W-1:0]  col_s1_reg;
    logic              last_s1_reg;
    logic [MUL_W-1:0]  mult_next;
    logic [MUL_W-1:0]  mult_reg;
    logic [COL_W-1:0]  col_s2_reg;
    logic              last_s2_reg;
    logic [OFF_W-1:0]  base;
    logic [OFF_W-1:0]  offset_next;
    logic [OFF_W-1:0]  offset_reg;
    logic              frame_end_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= cfg_wdata;
                REG_FRAME_HEIGHT: height_reg <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // frame size limits and clamped position
    always_comb
    begin
        pairs_raw = CMP_W'(width_reg[CFG_W-1:1]);
        lines_raw = CMP_W'(height_reg);
        if (pairs_raw == '0)
            pairs_cl = CMP_ONE;
        else if (pairs_raw > PAIR_MAX)
            pairs_cl = PAIR_MAX;
        else
            pairs_cl = pairs_raw;
        if (lines_raw == '0)
            lines_cl = CMP_ONE;
        else if (lines_raw > LINE_MAX)
            lines_cl = LINE_MAX;
        else
            lines_cl = lines_raw;
        pairs    = pairs_cl[PAIR_W-1:0];
        lines    = lines_cl[LINE_W-1:0];
        pairs_m1 = pairs - PAIR_W'(1);
        lines_m1 = lines - LINE_W'(1);
        col_c    = (PAIR_W'(col_reg) > pairs_m1) ? pairs_m1[COL_W-1:0] : col_reg;
        row_c    = (LINE_W'(row_reg) > lines_m1) ? lines_m1[ROW_W-1:0] : row_reg;
        last_col = (PAIR_W'(col_c) == pairs_m1);
        last_row = (LINE_W'(row_c) == lines_m1);
        line_rev_full = lines_m1 - LINE_W'(row_c);
    end

    // pair and line counters
    always_comb
    begin
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_c + ROW_W'(1);
        end
        else
        begin
            col_next = col_c + COL_W'(1);
            row_next = row_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (ctrl.accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // stage 1: reversed line and line pitch
    always_ff @(posedge clk)
    begin
        if (ctrl.adv1)
        begin
            line_rev_reg <= line_rev_full[ROW_W-1:0];
            wpix_reg     <= {pairs, 1'b0};
            col_s1_reg   <= col_c;
            last_s1_reg  <= last_col && last_row;
        end
    end

    // stage 2: line start in pixels
    assign mult_next = MUL_W'(line_rev_reg) * MUL_W'(wpix_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.adv2)
        begin
            mult_reg    <= mult_next;
            col_s2_reg  <= col_s1_reg;
            last_s2_reg <= last_s1_reg;
        end
    end

    // stage 3: pixel index times three bytes
    always_comb
    begin
        base        = OFF_W'(mult_reg) + OFF_W'({col_s2_reg, 1'b0});
        offset_next = base + {base[OFF_W-2:0], 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv3)
        begin
            offset_reg    <= offset_next;
            frame_end_reg <= last_s2_reg;
        end
    end

    assign byte_offset = offset_reg;
    assign frame_end   = frame_end_reg;

endmodule

`default_nettype wire

### rtl/yuyv_to_bottom_up_rgb.sv
// yuyv macropixel to two bgr pixels with bottom-up buffer offset
// input, product and output registers lie between the input beat and the output beat
// one macropixel per cycle if not stalled, two color lanes and address path in lockstep
// a stalled output holds its beat; empty stages still take new beats meanwhile
// reset clears stage valids and pair/line counters, frame size returns to 640 x 480
`default_nettype none

module yuyv_to_bottom_up_rgb #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // slave beat
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // luma_first, chroma_blue, luma_second, chroma_red
    input  wire logic [yuvrgb_pkg::IN_W-1:0]       s_tdata,
    // master beat
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // blue_first, green_first, red_first, blue_second, green_second,
    // red_second, byte_offset, zero fill
    output logic [yuvrgb_pkg::OUT_W-1:0]           m_tdata,
    // frame_end
    output logic                                   m_tlast,
    // configuration writes
    input  wire logic                              cfg_we,
    input  wire logic [yuvrgb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [yuvrgb_pkg::CFG_W-1:0]      cfg_wdata
);
    import yuvrgb_pkg::*;

    localparam int PAD_W = OUT_W - 6 * PIX_W - OFF_W;

    pipe_ctrl_t       ctrl;
    logic             v1_reg;
    logic             v1_next;
    logic             v2_reg;
    logic             v2_next;
    logic             v3_reg;
    logic             v3_next;
    logic [PIX_W-1:0] y0_reg;
    logic [PIX_W-1:0] u_reg;
    logic [PIX_W-1:0] y1_reg;
    logic [PIX_W-1:0] v_reg;
    logic [PIX_W-1:0] blue_first;
    logic [PIX_W-1:0] green_first;
    logic [PIX_W-1:0] red_first;
    logic [PIX_W-1:0] blue_second;
    logic [PIX_W-1:0] green_second;
    logic [PIX_W-1:0] red_second;
    logic [OFF_W-1:0] byte_offset;
    logic             frame_end;

    // stage advance: a stage moves when it is empty or the next one moves
    always_comb
    begin
        ctrl.adv3   = !v3_reg || m_tready;
        ctrl.adv2   = !v2_reg || ctrl.adv3;
        ctrl.adv1   = !v1_reg || ctrl.adv2;
        ctrl.accept = s_tvalid && ctrl.adv1;
        v1_next     = ctrl.adv1 ? s_tvalid : v1_reg;
        v2_next     = ctrl.adv2 ? v1_reg : v2_reg;
        v3_next     = ctrl.adv3 ? v2_reg : v3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // input beat register
    always_ff @(posedge clk)
    begin
        if (ctrl.adv1)
        begin
            y0_reg <= s_tdata[PIX_W-1:0];
            u_reg  <= s_tdata[2*PIX_W-1:PIX_W];
            y1_reg <= s_tdata[3*PIX_W-1:2*PIX_W];
            v_reg  <= s_tdata[4*PIX_W-1:3*PIX_W];
        end
    end

    // color lanes, one per pixel of the pair
    yuvrgb_lane u_lane_first (
        .clk      (clk),
        .ctrl     (ctrl),
        .luma     (y0_reg),
        .chroma_u (u_reg),
        .chroma_v (v_reg),
        .blue     (blue_first),
        .green    (green_first),
        .red      (red_first)
    );

    yuvrgb_lane u_lane_second (
        .clk      (clk),
        .ctrl     (ctrl),
        .luma     (y1_reg),
        .chroma_u (u_reg),
        .chroma_v (v_reg),
        .blue     (blue_second),
        .green    (green_second),
        .red      (red_second)
    );

    // position and buffer offset
    yuvrgb_addr #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_addr (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .byte_offset (byte_offset),
        .frame_end   (frame_end)
    );

    // merge lanes and offset into the output beat
    assign s_tready = ctrl.adv1;
    assign m_tvalid = v3_reg;
    assign m_tlast  = frame_end;
    assign m_tdata  = {{PAD_W{1'b0}}, byte_offset,
                       red_second, green_second, blue_second,
                       red_first, green_first, blue_first};

endmodule

`default_nettype wire
